[rtl/cnv_pkg.sv]
package cnv_pkg;

    // Image geometry
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_SIZE    = 3;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int COL_W       = 10;
    localparam int ROW_W       = 12;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 13;

    // Pixel and filter arithmetic
    localparam int PIXEL_W     = 8;
    localparam int PIXEL_MAX   = 255;
    localparam int TAPS        = 9;
    localparam int ROWS        = 3;
    localparam int PROD_W      = 17;
    localparam int ROWSUM_W    = 19;
    localparam int TOTAL_W     = 21;

    // Configuration port
    localparam int COEF_W      = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_COEF_TOP     = 3'd2,
        REG_COEF_MID     = 3'd3,
        REG_COEF_BOTTOM  = 3'd4
    } cfg_index_t;

    typedef logic [PIXEL_W-1:0] pixel_t;

    // Three mask rows; left coefficient in the low byte of each row
    typedef struct packed {
        logic [COEF_W-1:0] bottom;
        logic [COEF_W-1:0] mid;
        logic [COEF_W-1:0] top;
    } coef_t;

    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
    } geom_t;

    // One window request; tap k is row k/3, column k%3, row-major
    typedef struct packed {
        pixel_t [TAPS-1:0]  win;
        logic [COL_W-1:0]   cx;
        logic [ROW_W-1:0]   cy;
        logic               last;
    } win_item_t;

    typedef struct packed {
        logic               push;
        win_item_t          item;
    } q_push_t;

    typedef struct packed {
        logic               empty;
        logic [QCNT_W-1:0]  count;
        win_item_t          item;
    } q_status_t;

endpackage

[rtl/cnv_ram.sv]
module cnv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/cnv_front.sv]
module cnv_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  cnv_pkg::pixel_t       pixel_in,
    input  cnv_pkg::geom_t        geom,
    input  logic [cnv_pkg::QCNT_W-1:0] q_count,
    output cnv_pkg::q_push_t      q_push
);

    logic                          accept;
    logic [cnv_pkg::WIDTH_W-1:0]   w_eff;
    logic [cnv_pkg::HEIGHT_W-1:0]  h_eff;
    logic                          row_end;
    logic                          frame_end;
    logic                          emit_a;
    logic [cnv_pkg::QCNT_W:0]      in_flight;

    logic [cnv_pkg::COL_W-1:0]     col_reg, col_next;
    logic [cnv_pkg::ROW_W-1:0]     row_reg, row_next;

    logic                          b_valid_reg;
    logic                          b_emit_reg;
    cnv_pkg::pixel_t               b_pixel_reg;
    logic [cnv_pkg::ADDR_W-1:0]    b_addr_reg;
    logic [cnv_pkg::COL_W-1:0]     b_cx_reg;
    logic [cnv_pkg::ROW_W-1:0]     b_cy_reg;
    logic                          b_last_reg;

    cnv_pkg::pixel_t [cnv_pkg::TAPS-1:0] win_reg, win_next;

    cnv_pkg::pixel_t               upper_rdata;
    cnv_pkg::pixel_t               lower_rdata;

    // Hold input while queue plus the request in flight could fill it
    always_comb
    begin
        in_flight = {1'b0, q_count} + {{cnv_pkg::QCNT_W{1'b0}}, b_emit_reg};
        in_stall  = in_flight >= (cnv_pkg::QCNT_W + 1)'(cnv_pkg::QUEUE_DEPTH);
        accept    = in_valid && !in_stall;
    end

    // Saturate geometry and classify the current position
    always_comb
    begin
        if (geom.width < cnv_pkg::WIDTH_W'(cnv_pkg::MIN_SIZE))
        begin
            w_eff = cnv_pkg::WIDTH_W'(cnv_pkg::MIN_SIZE);
        end
        else if (geom.width > cnv_pkg::WIDTH_W'(cnv_pkg::MAX_WIDTH))
        begin
            w_eff = cnv_pkg::WIDTH_W'(cnv_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = geom.width;
        end

        if (geom.height < cnv_pkg::HEIGHT_W'(cnv_pkg::MIN_SIZE))
        begin
            h_eff = cnv_pkg::HEIGHT_W'(cnv_pkg::MIN_SIZE);
        end
        else if (geom.height > cnv_pkg::HEIGHT_W'(cnv_pkg::MAX_HEIGHT))
        begin
            h_eff = cnv_pkg::HEIGHT_W'(cnv_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = geom.height;
        end

        row_end   = ({1'b0, col_reg} + cnv_pkg::WIDTH_W'(1)) >= w_eff;
        frame_end = row_end && (({1'b0, row_reg} + cnv_pkg::HEIGHT_W'(1)) >= h_eff);
        emit_a    = (col_reg >= cnv_pkg::COL_W'(2)) && (row_reg >= cnv_pkg::ROW_W'(2));
    end

    // Advance the raster counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + cnv_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + cnv_pkg::COL_W'(1);
            end
        end
    end

    // Shift the window left and take the new column
    always_comb
    begin
        win_next = win_reg;
        if (b_valid_reg)
        begin
            for (int r = 0; r < cnv_pkg::ROWS; r++)
            begin
                win_next[3*r]     = win_reg[3*r + 1];
                win_next[3*r + 1] = win_reg[3*r + 2];
            end
            win_next[2] = upper_rdata;
            win_next[5] = lower_rdata;
            win_next[8] = b_pixel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
            b_emit_reg  <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            b_valid_reg <= accept;
            b_emit_reg  <= accept && emit_a;
            win_reg     <= win_next;
        end
    end

    // Carry pixel and position alongside the line store read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_pixel_reg <= pixel_in;
            b_addr_reg  <= col_reg;
            b_cx_reg    <= col_reg - cnv_pkg::COL_W'(1);
            b_cy_reg    <= row_reg - cnv_pkg::ROW_W'(1);
            b_last_reg  <= frame_end;
        end
    end

    // Line stores: read at accept, write back in the cycle after
    cnv_ram #(
        .WIDTH (cnv_pkg::PIXEL_W),
        .DEPTH (cnv_pkg::MAX_WIDTH)
    ) u_upper (
        .clk   (clk),
        .we    (b_valid_reg),
        .waddr (b_addr_reg),
        .wdata (lower_rdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (upper_rdata)
    );

    cnv_ram #(
        .WIDTH (cnv_pkg::PIXEL_W),
        .DEPTH (cnv_pkg::MAX_WIDTH)
    ) u_lower (
        .clk   (clk),
        .we    (b_valid_reg),
        .waddr (b_addr_reg),
        .wdata (b_pixel_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (lower_rdata)
    );

    // Push a request for every interior position
    always_comb
    begin
        q_push.push      = b_emit_reg;
        q_push.item.win  = win_next;
        q_push.item.cx   = b_cx_reg;
        q_push.item.cy   = b_cy_reg;
        q_push.item.last = b_last_reg;
    end

endmodule

[rtl/cnv_queue.sv]
module cnv_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  cnv_pkg::q_push_t   q_push,
    input  logic               pop,
    output cnv_pkg::q_status_t q_status
);

    cnv_pkg::win_item_t               mem_reg [cnv_pkg::QUEUE_DEPTH];
    logic [cnv_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [cnv_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [cnv_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             do_pop;

    // Advance pointers and count
    always_comb
    begin
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = q_push.push ? wr_ptr_reg + cnv_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + cnv_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (q_push.push && !do_pop)
        begin
            count_next = count_reg + cnv_pkg::QCNT_W'(1);
        end
        else if (!q_push.push && do_pop)
        begin
            count_next = count_reg - cnv_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed request
    always_ff @(posedge clk)
    begin
        if (q_push.push)
        begin
            mem_reg[wr_ptr_reg] <= q_push.item;
        end
    end

    always_comb
    begin
        q_status.empty = (count_reg == '0);
        q_status.count = count_reg;
        q_status.item  = mem_reg[rd_ptr_reg];
    end

endmodule

[rtl/cnv_back.sv]
module cnv_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cnv_pkg::coef_t             coef,
    input  cnv_pkg::q_status_t         q_status,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output cnv_pkg::pixel_t            pixel_out,
    output logic [cnv_pkg::COL_W-1:0]  center_x,
    output logic [cnv_pkg::ROW_W-1:0]  center_y,
    output logic                       frame_last
);

    logic                              adv;
    logic [cnv_pkg::TAPS*8-1:0]        coef_all;

    logic                              m_valid_reg;
    logic signed [cnv_pkg::PROD_W-1:0] m_prod_reg [cnv_pkg::TAPS];
    logic signed [cnv_pkg::PROD_W-1:0] m_prod_next [cnv_pkg::TAPS];
    logic [cnv_pkg::COL_W-1:0]         m_cx_reg;
    logic [cnv_pkg::ROW_W-1:0]         m_cy_reg;
    logic                              m_last_reg;

    logic                              p_valid_reg;
    logic signed [cnv_pkg::ROWSUM_W-1:0] p_sum_reg [cnv_pkg::ROWS];
    logic signed [cnv_pkg::ROWSUM_W-1:0] p_sum_next [cnv_pkg::ROWS];
    logic [cnv_pkg::COL_W-1:0]         p_cx_reg;
    logic [cnv_pkg::ROW_W-1:0]         p_cy_reg;
    logic                              p_last_reg;

    logic signed [cnv_pkg::TOTAL_W-1:0] total;
    cnv_pkg::pixel_t                   clamped;

    logic                              o_valid_reg;
    cnv_pkg::pixel_t                   o_pixel_reg;
    logic [cnv_pkg::COL_W-1:0]         o_cx_reg;
    logic [cnv_pkg::ROW_W-1:0]         o_cy_reg;
    logic                              o_last_reg;

    // Move the whole pipeline unless a finished result is held
    always_comb
    begin
        adv      = !o_valid_reg || !out_stall;
        pop      = adv && !q_status.empty;
        coef_all = {coef.bottom, coef.mid, coef.top};
    end

    // Multiply each tap by its signed coefficient
    always_comb
    begin
        for (int k = 0; k < cnv_pkg::TAPS; k++)
        begin
            m_prod_next[k] = $signed(coef_all[8*k +: 8])
                           * $signed({1'b0, q_status.item.win[k]});
        end
    end

    // Sum each mask row
    always_comb
    begin
        for (int r = 0; r < cnv_pkg::ROWS; r++)
        begin
            p_sum_next[r] = {{2{m_prod_reg[3*r][cnv_pkg::PROD_W-1]}}, m_prod_reg[3*r]}
                + {{2{m_prod_reg[3*r+1][cnv_pkg::PROD_W-1]}}, m_prod_reg[3*r+1]}
                + {{2{m_prod_reg[3*r+2][cnv_pkg::PROD_W-1]}}, m_prod_reg[3*r+2]};
        end
    end

    // Add the rows and clamp to the pixel range
    always_comb
    begin
        total = {{2{p_sum_reg[0][cnv_pkg::ROWSUM_W-1]}}, p_sum_reg[0]}
              + {{2{p_sum_reg[1][cnv_pkg::ROWSUM_W-1]}}, p_sum_reg[1]}
              + {{2{p_sum_reg[2][cnv_pkg::ROWSUM_W-1]}}, p_sum_reg[2]};
        if (total[cnv_pkg::TOTAL_W-1])
        begin
            clamped = '0;
        end
        else if (total > cnv_pkg::TOTAL_W'(cnv_pkg::PIXEL_MAX))
        begin
            clamped = cnv_pkg::PIXEL_W'(cnv_pkg::PIXEL_MAX);
        end
        else
        begin
            clamped = total[cnv_pkg::PIXEL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= pop;
            p_valid_reg <= m_valid_reg;
            o_valid_reg <= p_valid_reg;
        end
    end

    // Advance payload through the stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_prod_reg  <= m_prod_next;
            m_cx_reg    <= q_status.item.cx;
            m_cy_reg    <= q_status.item.cy;
            m_last_reg  <= q_status.item.last;
            p_sum_reg   <= p_sum_next;
            p_cx_reg    <= m_cx_reg;
            p_cy_reg    <= m_cy_reg;
            p_last_reg  <= m_last_reg;
            o_pixel_reg <= clamped;
            o_cx_reg    <= p_cx_reg;
            o_cy_reg    <= p_cy_reg;
            o_last_reg  <= p_last_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign pixel_out  = o_pixel_reg;
    assign center_x   = o_cx_reg;
    assign center_y   = o_cy_reg;
    assign frame_last = o_last_reg;

endmodule

[rtl/image_convolution_3x3_clamp.sv]
// Path: window stage, queue, then the multiply, row-sum and output stages.
// Throughput: one pixel per cycle unless in_stall; the line stores are read at
// accept and written in the cycle after through separate ports, and the back
// pipeline sustains one result per cycle unless out_stall, behind a 4-entry queue.
// Reset (rst_n, asynchronous): counters, queue and pipeline empty, window zero,
// width 640, height 480, coefficients zero; line store contents stay undefined.
module image_convolution_3x3_clamp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cnv_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cnv_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        pixel_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        pixel_out,
    output logic [9:0]                        center_x,
    output logic [11:0]                       center_y,
    output logic                              frame_last
);

    cnv_pkg::geom_t     geom_reg;
    cnv_pkg::coef_t     coef_reg;
    cnv_pkg::q_push_t   q_push;
    cnv_pkg::q_status_t q_status;
    logic               pop;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.width  <= cnv_pkg::WIDTH_W'(cnv_pkg::RESET_WIDTH);
            geom_reg.height <= cnv_pkg::HEIGHT_W'(cnv_pkg::RESET_HEIGHT);
            coef_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (cnv_pkg::cfg_index_t'(cfg_index))
                cnv_pkg::REG_IMAGE_WIDTH:
                begin
                    geom_reg.width <= cfg_data[cnv_pkg::WIDTH_W-1:0];
                end
                cnv_pkg::REG_IMAGE_HEIGHT:
                begin
                    geom_reg.height <= cfg_data[cnv_pkg::HEIGHT_W-1:0];
                end
                cnv_pkg::REG_COEF_TOP:
                begin
                    coef_reg.top <= cfg_data[cnv_pkg::COEF_W-1:0];
                end
                cnv_pkg::REG_COEF_MID:
                begin
                    coef_reg.mid <= cfg_data[cnv_pkg::COEF_W-1:0];
                end
                cnv_pkg::REG_COEF_BOTTOM:
                begin
                    coef_reg.bottom <= cfg_data[cnv_pkg::COEF_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    cnv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .pixel_in (pixel_in),
        .geom     (geom_reg),
        .q_count  (q_status.count),
        .q_push   (q_push)
    );

    cnv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .pop      (pop),
        .q_status (q_status)
    );

    cnv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef       (coef_reg),
        .q_status   (q_status),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_out  (pixel_out),
        .center_x   (center_x),
        .center_y   (center_y),
        .frame_last (frame_last)
    );

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    import cnv_pkg::*;

    localparam int DRAIN_CYCLES  = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int TALL_PIXELS   = 60;
    // first directed frame, first pixel in the low byte
    localparam logic [71:0] FIRST_FRAME = 72'hFE_80_01_00_FF_55_AA_FF_00;

    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    typedef struct packed {
        pixel_t             value;
        logic [COL_W-1:0]   cx;
        logic [ROW_W-1:0]   cy;
        logic               last;
    } filtered_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    cfg_index_t             cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    pixel_t                 pixel_in = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    pixel_t                 pixel_out;
    logic [9:0]             center_x;
    logic [11:0]            center_y;
    logic                   frame_last;

    // Mirror of the block: registers, line history, window, position
    logic [WIDTH_W-1:0]     width_reg = WIDTH_W'(RESET_WIDTH);
    logic [HEIGHT_W-1:0]    height_reg = HEIGHT_W'(RESET_HEIGHT);
    logic [COEF_W-1:0]      coef_rows [3] = '{default: '0};
    pixel_t                 prev2_row [MAX_WIDTH] = '{default: '0};
    pixel_t                 prev1_row [MAX_WIDTH] = '{default: '0};
    pixel_t                 window_px [TAPS] = '{default: '0};
    int                     col_pos = 0;
    int                     row_pos = 0;

    filtered_t              filtered_due [$];
    filtered_t              due_now;
    pixel_t                 pending_pixels [$];

    // Stimulus-side view of the raster position
    int                     gen_w = RESET_WIDTH;
    int                     gen_h = RESET_HEIGHT;
    int                     gen_col = 0;
    int                     gen_row = 0;
    int                     pushed_count = 0;
    int                     random_start;
    int                     fail_count = 0;

    logic                   in_taken = 1'b0;
    int                     burst_left = 1;
    int                     gap_left = 0;
    stall_mode_t            stall_mode = STALL_NONE;
    int                     stall_seg = 0;
    int                     watchdog_idle = 0;

    image_convolution_3x3_clamp DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_in   (pixel_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_out  (pixel_out),
        .center_x   (center_x),
        .center_y   (center_y),
        .frame_last (frame_last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the mirror by one accepted pixel and queue the filtered value it yields
    task automatic filter_step(input pixel_t px);
        int         w;
        int         h;
        int         sum;
        int         m;
        int         k;
        pixel_t     up;
        pixel_t     lo;
        logic       row_end;
        logic       frame_end;
        filtered_t  res;
        w = clamp_int(int'(width_reg), MIN_SIZE, MAX_WIDTH);
        h = clamp_int(int'(height_reg), MIN_SIZE, MAX_HEIGHT);
        up = prev2_row[col_pos];
        lo = prev1_row[col_pos];
        row_end = (col_pos + 1 >= w);
        frame_end = row_end && (row_pos + 1 >= h);
        // shift the window one column left, new column on the right
        for (m = 0; m < ROWS; m++)
        begin
            window_px[m * 3] = window_px[m * 3 + 1];
            window_px[m * 3 + 1] = window_px[m * 3 + 2];
        end
        window_px[2] = up;
        window_px[5] = lo;
        window_px[8] = px;
        prev2_row[col_pos] = lo;
        prev1_row[col_pos] = px;
        // full window inside the image: weighted sum, clamped
        if (col_pos >= 2 && row_pos >= 2)
        begin
            sum = 0;
            for (m = 0; m < ROWS; m++)
                for (k = 0; k < 3; k++)
                    sum += int'($signed(coef_rows[m][8 * k +: 8])) * int'(window_px[3 * m + k]);
            sum = clamp_int(sum, 0, PIXEL_MAX);
            res.value = pixel_t'(sum);
            res.cx = COL_W'(col_pos - 1);
            res.cy = ROW_W'(row_pos - 1);
            res.last = frame_end;
            filtered_due.push_back(res);
        end
        if (row_end)
        begin
            col_pos = 0;
            row_pos = frame_end ? 0 : row_pos + 1;
        end
        else
            col_pos++;
    endtask

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (actv !== expv)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
        end
    endtask

    // Sample both handshakes and the register port at the rising edge
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (filtered_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %0d at (%0d,%0d)",
                             $time, pixel_out, center_x, center_y);
                end
                else
                begin
                    due_now = filtered_due.pop_front();
                    check_field("pixel_out", 32'(due_now.value), 32'(pixel_out));
                    check_field("center_x", 32'(due_now.cx), 32'(center_x));
                    check_field("center_y", 32'(due_now.cy), 32'(center_y));
                    check_field("frame_last", 32'(due_now.last), 32'(frame_last));
                end
            end
            if (in_valid && !in_stall)
                filter_step(pixel_in);
            if (cfg_we)
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg = cfg_data[WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_W-1:0];
                    REG_COEF_TOP:     coef_rows[0] = cfg_data;
                    REG_COEF_MID:     coef_rows[1] = cfg_data;
                    REG_COEF_BOTTOM:  coef_rows[2] = cfg_data;
                    default:          ;
                endcase
        end
    end

    // Present pixel requests in bursts; hold a request until it is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && !in_taken))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_pixels.size() > 0)
            begin
                pixel_in <= pending_pixels.pop_front();
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                            : $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall the result side in segments of varying density
    always @(negedge clk)
    begin
        if (stall_seg == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_seg = $urandom_range(16, 160);
        end
        stall_seg--;
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_SPARSE:   out_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: out_stall <= (stall_seg % 3 != 0);
            default:        out_stall <= ($urandom_range(0, 7) < 6);
        endcase
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                watchdog_idle <= 0;
            else
                watchdog_idle <= watchdog_idle + 1;
            if (watchdog_idle >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_IMAGE_WIDTH)
            gen_w = clamp_int(int'(val[WIDTH_W-1:0]), MIN_SIZE, MAX_WIDTH);
        else if (idx == REG_IMAGE_HEIGHT)
            gen_h = clamp_int(int'(val[HEIGHT_W-1:0]), MIN_SIZE, MAX_HEIGHT);
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every request is taken and every result is back, then drain
    task automatic wait_idle();
        @(posedge clk);
        while (pending_pixels.size() != 0 || in_valid || filtered_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_pixel(input pixel_t v);
        pending_pixels.push_back(v);
        pushed_count++;
        if (gen_col + 1 >= gen_w)
        begin
            gen_col = 0;
            gen_row = (gen_row + 1 >= gen_h) ? 0 : gen_row + 1;
        end
        else
            gen_col++;
    endtask

    task automatic push_random_pixel();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            push_pixel('0);
        else if (pick == 1)
            push_pixel(8'hFF);
        else
            push_pixel(pixel_t'($urandom));
    endtask

    // Complete the current frame, then add whole frames up to k in total
    task automatic run_frames(input int k);
        repeat (k)
        begin
            push_random_pixel();
            while (gen_col != 0 || gen_row != 0)
                push_random_pixel();
        end
    endtask

    function automatic int pick_width();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom_range(0, 2);
        if (r == 1)
            return $urandom_range(13, 64);
        return $urandom_range(3, 12);
    endfunction

    function automatic int pick_height();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom_range(0, 2);
        if (r == 1)
            return $urandom_range(7, 16);
        return $urandom_range(3, 6);
    endfunction

    // Mix wide random masks with small and extreme ones so sums land mid-range too
    function automatic logic [COEF_W-1:0] pick_coef_row();
        logic [COEF_W-1:0] v;
        int r;
        int b;
        r = $urandom_range(0, 99);
        for (b = 0; b < 3; b++)
        begin
            if (r < 20)
                v[8 * b +: 8] = 8'($urandom);
            else if (r < 60)
                v[8 * b +: 8] = 8'($urandom_range(0, 6) - 3);
            else if (r < 75)
                case ($urandom_range(0, 3))
                    0:       v[8 * b +: 8] = 8'h7F;
                    1:       v[8 * b +: 8] = 8'h80;
                    2:       v[8 * b +: 8] = 8'h00;
                    default: v[8 * b +: 8] = 8'hFF;
                endcase
            else
                v[8 * b +: 8] = 8'($urandom_range(0, 1));
        end
        return v;
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // smallest frame with coefficients still at reset: one zero result, frame end
        write_reg(REG_IMAGE_WIDTH, 24'd3);
        write_reg(REG_IMAGE_HEIGHT, 24'd3);
        end_writes();
        for (int i = 0; i < 9; i++)
            push_pixel(FIRST_FRAME[8 * i +: 8]);

        // sizes below the minimum saturate; all-max positive mask clamps high
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 24'd0);
        write_reg(REG_IMAGE_HEIGHT, 24'd2);
        write_reg(REG_COEF_TOP, 24'h7F7F7F);
        write_reg(REG_COEF_MID, 24'h7F7F7F);
        write_reg(REG_COEF_BOTTOM, 24'h7F7F7F);
        end_writes();
        repeat (9) push_pixel(8'hFF);

        // all-min negative mask clamps low
        wait_idle();
        write_reg(REG_COEF_TOP, 24'h808080);
        write_reg(REG_COEF_MID, 24'h808080);
        write_reg(REG_COEF_BOTTOM, 24'h808080);
        end_writes();
        repeat (9) push_pixel(8'hFF);

        // random phases: new geometry at frame start, shrink or live mask change mid-frame
        random_start = pushed_count;
        while (pushed_count - random_start < RANDOM_ITEMS)
        begin
            wait_idle();
            if (gen_col == 0 && gen_row == 0)
            begin
                write_reg(REG_IMAGE_WIDTH, {13'($urandom), 11'(pick_width())});
                write_reg(REG_IMAGE_HEIGHT, {11'($urandom), 13'(pick_height())});
            end
            else
            begin
                // shrink only once two full rows of history exist at this width
                if (gen_row >= 2 && $urandom_range(0, 1) == 1)
                    write_reg(REG_IMAGE_WIDTH, 24'($urandom_range(MIN_SIZE, gen_w)));
                if ($urandom_range(0, 1) == 1)
                    write_reg(REG_IMAGE_HEIGHT, 24'(pick_height()));
            end
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_COEF_TOP, pick_coef_row());
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_COEF_MID, pick_coef_row());
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_COEF_BOTTOM, pick_coef_row());
            end_writes();
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, gen_w * gen_h)) push_random_pixel();
            else
                run_frames($urandom_range(1, 3));
        end

        // close any open frame before changing the geometry
        wait_idle();
        run_frames(1);

        // height above the maximum saturates: rows keep counting well past a small frame
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 24'd3);
        write_reg(REG_IMAGE_HEIGHT, {11'($urandom), 13'h1FFF});
        write_reg(REG_COEF_MID, pick_coef_row());
        end_writes();
        repeat (TALL_PIXELS) push_random_pixel();

        // reduce the height so the frame ends at the next row end
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 24'd3);
        end_writes();
        run_frames(1);

        wait_idle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
